// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the packet continuity monitor.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every rising edge outside of reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside of reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  `ASSERT_CLK(name, clk, rst, !(cond), msg)
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ----- src/tpcm_pkg.sv -----
// Shared types, constants and helpers of the transport stream continuity monitor.
// Depends on nothing; the top level, front end and back end use it.
package tpcm_pkg;

  localparam int CounterWidth  = 32;
  localparam int PidCount      = 8192;
  localparam int PidWidth      = $clog2(PidCount);
  localparam int PidHighWidth  = PidWidth - 8;
  localparam int OutCountWidth = 32;
  localparam int CcWidth       = 4;
  localparam int TeiBit        = 7;

  // Depth of the command queue between the front end and the back end.
  localparam int CmdQueueDepth = 2;
  localparam int CmdPtrWidth   = $clog2(CmdQueueDepth);
  localparam int CmdCountWidth = $clog2(CmdQueueDepth + 1);

  localparam logic [7:0] SyncByte    = 8'h47;
  localparam logic [7:0] SyncByteInv = 8'hB8;

  localparam logic [2:0] StatusOk         = 3'd0;
  localparam logic [2:0] StatusSyncErr    = 3'd1;
  localparam logic [2:0] StatusTransport  = 3'd2;
  localparam logic [2:0] StatusDiscont    = 3'd3;
  localparam logic [2:0] StatusReadReply  = 3'd4;

  typedef logic [CounterWidth-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_SYNC_ERR,
    CMD_TRANSPORT_ERR,
    CMD_PACKET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 flagged;
    logic [PidWidth-1:0]  pid;
    logic [CcWidth-1:0]   cc;
  } cmd_t;

  typedef struct packed {
    logic               seen;
    logic [CcWidth-1:0] cc;
    count_t             disc;
    count_t             pkt;
  } pid_row_t;

  typedef struct packed {
    logic                action;
    logic [7:0]          header_byte0;
    logic [7:0]          header_byte1;
    logic [7:0]          header_byte2;
    logic [7:0]          header_byte3;
    logic [PidWidth-1:0] query_pid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [PidWidth-1:0]      pid;
    logic [OutCountWidth-1:0] pid_packet_count;
    logic [OutCountWidth-1:0] pid_discontinuity_count;
    logic [OutCountWidth-1:0] total_packets;
    logic [OutCountWidth-1:0] sync_errors;
    logic [OutCountWidth-1:0] sync_errors_flagged;
    logic [OutCountWidth-1:0] malformed_packets;
  } out_item_t;

  typedef struct packed {
    logic cmd_pop;
    logic clearing;
  } back_status_t;

  // Low bits of a counter, zero extended when the counter is narrower.
  function automatic logic [OutCountWidth-1:0] count_out(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OutCountWidth-1:0];
  endfunction

endpackage

// ----- src/ts_packet_continuity_monitor.sv -----
// Top level of the MPEG transport stream continuity monitor.
// Depends on tpcm_pkg, tpcm_front, tpcm_back and tpcm_ram.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------
//   input     push / full          item   (tpcm_pkg::in_item_t)
//   result    empty / pop          result (tpcm_pkg::out_item_t)
//   config    cfg_write            cfg_data (accept inverted sync)
//
// In the back end each transaction first reads the per-PID row from the
// RAM (registered read) and then updates the row, the global counters
// and the result register.
// The front end accepts one transaction per cycle while full is low into
// a two-entry queue, so input is still taken while a finished result
// waits to be popped, until the queue fills. After reset the per-PID RAM
// is cleared one row per cycle, all 8192 rows, and full stays high until
// that pass is done; configuration writes are taken throughout.
module ts_packet_continuity_monitor (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                push,
  output logic                full,
  input  tpcm_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output tpcm_pkg::out_item_t result
);

  // Classified commands pass from the front end to the back end through
  // the queue inside the front end; the back end pops them when its
  // result register will be free.
  logic                   cmd_valid;
  tpcm_pkg::cmd_t         cmd;
  tpcm_pkg::back_status_t back_st;

  tpcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .back_st  (back_st)
  );

  tpcm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_in   (cmd),
    .back_st  (back_st),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ----- src/tpcm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module tpcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tpcm_front.sv -----
// Front end: holds the sync setting, classifies each transaction and queues it.
// Depends on tpcm_pkg.
module tpcm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_data,
  input  logic                   push,
  output logic                   full,
  input  tpcm_pkg::in_item_t     item,
  output logic                   cmd_valid,
  output tpcm_pkg::cmd_t         cmd,
  input  tpcm_pkg::back_status_t back_st
);

  logic                                 accept_inverted_sync;
  tpcm_pkg::cmd_t                       q [tpcm_pkg::CmdQueueDepth];
  logic [tpcm_pkg::CmdPtrWidth-1:0]     wr_ptr;
  logic [tpcm_pkg::CmdPtrWidth-1:0]     rd_ptr;
  logic [tpcm_pkg::CmdCountWidth-1:0]   count;
  logic                                 push_ok;
  logic                                 sync_ok;
  tpcm_pkg::cmd_t                       cmd_in;

  assign full      = (count == tpcm_pkg::CmdCountWidth'(tpcm_pkg::CmdQueueDepth)) ||
                     back_st.clearing;
  assign push_ok   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    sync_ok = (item.header_byte0 == tpcm_pkg::SyncByte) ||
              (accept_inverted_sync && item.header_byte0 == tpcm_pkg::SyncByteInv);
    cmd_in.flagged = item.header_byte1[tpcm_pkg::TeiBit];
    cmd_in.cc      = item.header_byte3[tpcm_pkg::CcWidth-1:0];
    cmd_in.pid     = {item.header_byte1[tpcm_pkg::PidHighWidth-1:0], item.header_byte2};
    if (item.action) begin
      cmd_in.kind = tpcm_pkg::CMD_READ;
      cmd_in.pid  = item.query_pid;
    end else if (!sync_ok) begin
      cmd_in.kind = tpcm_pkg::CMD_SYNC_ERR;
    end else if (item.header_byte1[tpcm_pkg::TeiBit]) begin
      cmd_in.kind = tpcm_pkg::CMD_TRANSPORT_ERR;
    end else begin
      cmd_in.kind = tpcm_pkg::CMD_PACKET;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      accept_inverted_sync <= 1'b1;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (cfg_write) begin
        accept_inverted_sync <= cfg_data;
      end
      if (push_ok) begin
        wr_ptr <= (wr_ptr == tpcm_pkg::CmdPtrWidth'(tpcm_pkg::CmdQueueDepth - 1)) ?
                  '0 : wr_ptr + tpcm_pkg::CmdPtrWidth'(1);
      end
      if (back_st.cmd_pop) begin
        rd_ptr <= (rd_ptr == tpcm_pkg::CmdPtrWidth'(tpcm_pkg::CmdQueueDepth - 1)) ?
                  '0 : rd_ptr + tpcm_pkg::CmdPtrWidth'(1);
      end
      case ({push_ok, back_st.cmd_pop})
        2'b10:   count <= count + tpcm_pkg::CmdCountWidth'(1);
        2'b01:   count <= count - tpcm_pkg::CmdCountWidth'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/tpcm_back.sv -----
// Back end: per-PID store, global counters and the result register.
// Depends on tpcm_pkg, tpcm_ram and assert_macros.svh.
`include "assert_macros.svh"
module tpcm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  tpcm_pkg::cmd_t         cmd_in,
  output tpcm_pkg::back_status_t back_st,
  output logic                   empty,
  input  logic                   pop,
  output tpcm_pkg::out_item_t    result
);

  typedef enum logic [1:0] {CLEAR, IDLE, EXEC} state_t;

  state_t                          state;
  logic [tpcm_pkg::PidWidth-1:0]   clr_addr;
  tpcm_pkg::cmd_t                  cmd;
  tpcm_pkg::count_t                total;
  tpcm_pkg::count_t                sync_bad;
  tpcm_pkg::count_t                sync_flag;
  tpcm_pkg::count_t                malformed;
  logic                            out_valid;

  logic                            take;
  logic                            ram_we;
  logic [tpcm_pkg::PidWidth-1:0]   ram_waddr;
  tpcm_pkg::pid_row_t              ram_wdata;
  tpcm_pkg::pid_row_t              row;
  tpcm_pkg::pid_row_t              row_next;
  tpcm_pkg::pid_row_t              row_rep;
  logic [tpcm_pkg::CcWidth-1:0]    cc_expect;
  logic                            discont;
  logic                            is_packet;
  tpcm_pkg::count_t                total_next;
  tpcm_pkg::count_t                sync_bad_next;
  tpcm_pkg::count_t                sync_flag_next;
  tpcm_pkg::count_t                malformed_next;
  logic [2:0]                      status_next;

  assign take    = (state == IDLE) && cmd_valid && (!out_valid || pop);
  assign back_st = '{cmd_pop: take, clearing: (state == CLEAR)};
  assign empty   = !out_valid;

  tpcm_ram #(
    .Width($bits(tpcm_pkg::pid_row_t)),
    .Depth(tpcm_pkg::PidCount)
  ) u_pid_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cmd_in.pid),
    .rdata(row)
  );

  always_comb begin
    is_packet = (cmd.kind == tpcm_pkg::CMD_PACKET);
    cc_expect = row.cc + 4'd1;
    discont   = row.seen && (cc_expect != cmd.cc);
    row_next.seen = 1'b1;
    row_next.cc   = cmd.cc;
    row_next.pkt  = row.pkt + 1'b1;
    row_next.disc = discont ? row.disc + 1'b1 : row.disc;
    row_rep = is_packet ? row_next : row;

    ram_we    = (state == CLEAR) || ((state == EXEC) && is_packet);
    ram_waddr = (state == CLEAR) ? clr_addr : cmd.pid;
    ram_wdata = (state == CLEAR) ? '0 : row_next;

    total_next     = total + tpcm_pkg::count_t'(cmd.kind != tpcm_pkg::CMD_READ);
    sync_bad_next  = sync_bad + tpcm_pkg::count_t'(cmd.kind == tpcm_pkg::CMD_SYNC_ERR);
    sync_flag_next = sync_flag +
                     tpcm_pkg::count_t'(cmd.kind == tpcm_pkg::CMD_SYNC_ERR && cmd.flagged);
    malformed_next = malformed +
                     tpcm_pkg::count_t'(cmd.kind == tpcm_pkg::CMD_TRANSPORT_ERR);

    case (cmd.kind)
      tpcm_pkg::CMD_READ:          status_next = tpcm_pkg::StatusReadReply;
      tpcm_pkg::CMD_SYNC_ERR:      status_next = tpcm_pkg::StatusSyncErr;
      tpcm_pkg::CMD_TRANSPORT_ERR: status_next = tpcm_pkg::StatusTransport;
      tpcm_pkg::CMD_PACKET:        status_next = discont ? tpcm_pkg::StatusDiscont
                                                         : tpcm_pkg::StatusOk;
      default:                     status_next = tpcm_pkg::StatusOk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      total     <= '0;
      sync_bad  <= '0;
      sync_flag <= '0;
      malformed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == tpcm_pkg::PidWidth'(tpcm_pkg::PidCount - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (take) begin
            cmd   <= cmd_in;
            state <= EXEC;
          end
        end
        EXEC: begin
          total     <= total_next;
          sync_bad  <= sync_bad_next;
          sync_flag <= sync_flag_next;
          malformed <= malformed_next;
          result.status                  <= status_next;
          result.pid                     <= cmd.pid;
          result.pid_packet_count        <= tpcm_pkg::count_out(row_rep.pkt);
          result.pid_discontinuity_count <= tpcm_pkg::count_out(row_rep.disc);
          result.total_packets           <= tpcm_pkg::count_out(total_next);
          result.sync_errors             <= tpcm_pkg::count_out(sync_bad_next);
          result.sync_errors_flagged     <= tpcm_pkg::count_out(sync_flag_next);
          result.malformed_packets       <= tpcm_pkg::count_out(malformed_next);
          out_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_take_while_clearing, clk, rst, (state == CLEAR) && take,
                "command taken during the clearing pass")
  `ASSERT_CLK(a_result_slot_free, clk, rst, (state == EXEC) |-> !out_valid,
              "result register still occupied when a command completes")
  `ASSERT_CLK(a_result_from_exec, clk, rst, $rose(out_valid) |-> $past(state == EXEC),
              "result appeared without a completed command")

endmodule
